@@ rtl/core/smi_pkg.sv @@
// shared types and constants for the management serial bus frame master
`default_nettype none
package smi_pkg;

	// function codes of an input item
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_HOLD_TICKS    = 2'd0;
	localparam logic [1:0] REG_PREAMBLE_ONES = 2'd1;
	localparam logic [1:0] REG_PHY_ID        = 2'd2;

	localparam logic [7:0] HOLD_TICKS_RST    = 8'd20;
	localparam logic [5:0] PREAMBLE_ONES_RST = 6'd6;
	localparam logic [1:0] PHY_ID_RST        = 2'd0;

	// frame lengths after the preamble
	localparam logic [5:0] WRITE_LEN = 6'd32;
	localparam logic [5:0] READ_LEN  = 6'd15;
	localparam logic [5:0] RECV_LEN  = 6'd16;

	localparam logic [3:0] SOF_WRITE = 4'b0101;
	localparam logic [3:0] SOF_READ  = 4'b0110;
	localparam logic [1:0] TA_WRITE  = 2'b10;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} in_item_t;

	typedef struct packed {
		logic        clock_pulse;
		logic        line_drive;
		logic        line_level;
		logic        busy_res;
		logic [15:0] read_word;
		logic        read_done;
		logic        rejected;
	} out_item_t;

	typedef struct packed {
		logic [7:0] hold_ticks;
		logic [5:0] preamble_ones;
		logic [1:0] phy_id;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/smi_mdio_frame_master.sv @@
// top level of the management serial bus frame master
`default_nettype none
// Management serial bus frame master. Each input item is one bit cell: a
// tick emits the next cell of the running frame, a write or read command
// while idle loads a frame (hold low, preamble ones, start/op, id, register,
// data phase). Exactly one result comes back for every item. Items are taken
// one per cycle while the input does not stall: an input register feeds the
// frame sequencer, whose cell is captured in an output register, so a result
// is offered once its item has passed both registers. A new item is taken
// while an older result still waits; with the output stalled and the input
// register full, the input stalls.
// Configuration (hold_ticks 0x0, preamble_ones 0x4, phy_id 0x8) is written
// over APB while no frame is in flight; the user keeps to it, not the block.
module smi_mdio_frame_master (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire smi_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output smi_pkg::out_item_t      out_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import smi_pkg::*;

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      out_valid_q;
	out_item_t res;
	logic      advance;
	logic      in_take;
	logic      cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks    <= HOLD_TICKS_RST;
			cfg_q.preamble_ones <= PREAMBLE_ONES_RST;
			cfg_q.phy_id        <= PHY_ID_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_HOLD_TICKS:    cfg_q.hold_ticks    <= pwdata[7:0];
				REG_PREAMBLE_ONES: cfg_q.preamble_ones <= pwdata[5:0];
				REG_PHY_ID:        cfg_q.phy_id        <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_HOLD_TICKS:    prdata = {24'd0, cfg_q.hold_ticks};
			REG_PREAMBLE_ONES: prdata = {26'd0, cfg_q.preamble_ones};
			REG_PHY_ID:        prdata = {30'd0, cfg_q.phy_id};
			default:           prdata = '0;
		endcase
	end

	// stage 1 moves on when the output register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	smi_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = res_q;

endmodule
`default_nettype wire

@@ rtl/core/smi_frame_core.sv @@
// frame sequencer: one bit cell per item, state advances on each step
`default_nettype none
module smi_frame_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire smi_pkg::in_item_t item,
	input  wire smi_pkg::cfg_t     cfg,
	output smi_pkg::out_item_t     res
);
	import smi_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HOLD,
		PH_PRE,
		PH_SEND,
		PH_RECV
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [5:0]  bit_count_q, bit_count_d;
	logic [7:0]  hold_count_q, hold_count_d;
	logic [31:0] send_shift_q, send_shift_d;
	logic [15:0] recv_shift_q, recv_shift_d;
	logic        is_read_q, is_read_d;

	logic        start;
	logic [5:0]  send_len;
	logic [5:0]  bit_count_dec;
	logic [7:0]  hold_count_dec;

	assign start          = (item.func == FUNC_WRITE) || (item.func == FUNC_READ);
	assign send_len       = is_read_q ? READ_LEN : WRITE_LEN;
	assign bit_count_dec  = bit_count_q - 6'd1;
	assign hold_count_dec = hold_count_q - 8'd1;

	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		hold_count_d = hold_count_q;
		send_shift_d = send_shift_q;
		recv_shift_d = recv_shift_q;
		is_read_d    = is_read_q;
		res          = '0;

		if (phase_q == PH_IDLE) begin
			if (start) begin
				res.busy_res = 1'b1;
				is_read_d    = (item.func == FUNC_READ);
				if (item.func == FUNC_READ) begin
					send_shift_d = {SOF_READ, cfg.phy_id, item.reg_addr, 18'd0};
				end else begin
					send_shift_d = {SOF_WRITE, cfg.phy_id, item.reg_addr, TA_WRITE,
						item.write_data};
				end
				recv_shift_d = '0;
				// skip empty hold and preamble parts
				if (cfg.hold_ticks != 8'd0) begin
					phase_d      = PH_HOLD;
					hold_count_d = cfg.hold_ticks;
				end else if (cfg.preamble_ones != 6'd0) begin
					phase_d     = PH_PRE;
					bit_count_d = cfg.preamble_ones;
				end else begin
					phase_d     = PH_SEND;
					bit_count_d = (item.func == FUNC_READ) ? READ_LEN : WRITE_LEN;
				end
			end
		end else begin
			res.busy_res = 1'b1;
			res.rejected = start;
			unique case (phase_q)
				PH_HOLD: begin
					res.line_drive = 1'b1;
					hold_count_d   = hold_count_dec;
					if (hold_count_dec == 8'd0) begin
						if (cfg.preamble_ones != 6'd0) begin
							phase_d     = PH_PRE;
							bit_count_d = cfg.preamble_ones;
						end else begin
							phase_d     = PH_SEND;
							bit_count_d = send_len;
						end
					end
				end
				PH_PRE: begin
					res.clock_pulse = 1'b1;
					res.line_drive  = 1'b1;
					res.line_level  = 1'b1;
					bit_count_d     = bit_count_dec;
					if (bit_count_dec == 6'd0) begin
						phase_d     = PH_SEND;
						bit_count_d = send_len;
					end
				end
				PH_SEND: begin
					res.clock_pulse = 1'b1;
					res.line_drive  = 1'b1;
					res.line_level  = send_shift_q[31];
					send_shift_d    = {send_shift_q[30:0], 1'b0};
					bit_count_d     = bit_count_dec;
					if (bit_count_dec == 6'd0) begin
						if (is_read_q) begin
							phase_d      = PH_RECV;
							bit_count_d  = RECV_LEN;
							recv_shift_d = '0;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				PH_RECV: begin
					res.clock_pulse = 1'b1;
					recv_shift_d    = {recv_shift_q[14:0], item.mdio_in};
					bit_count_d     = bit_count_dec;
					if (bit_count_dec == 6'd0) begin
						res.read_done = 1'b1;
						res.read_word = recv_shift_d;
						phase_d       = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			hold_count_q <= '0;
			send_shift_q <= '0;
			recv_shift_q <= '0;
			is_read_q    <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			hold_count_q <= hold_count_d;
			send_shift_q <= send_shift_d;
			recv_shift_q <= recv_shift_d;
			is_read_q    <= is_read_d;
		end
	end

endmodule
`default_nettype wire
